/* rtl/mow_pkg.sv */
// shared types, constants and helper functions for the mecanum odometry integrator
// no dependencies; imported by mow_cordic, the top level and the testbench
package mow_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIAMETER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_X_SLIP_GAIN = 1'b1;

  localparam logic [15:0] WHEEL_DIAMETER_RST = 16'd1613;
  localparam logic [15:0] X_SLIP_GAIN_RST = 16'd23918;

  // pi in Q.40
  localparam logic [63:0] PI_Q40 = 64'd3454217652358;

  // step magnitude width: |F*sin + L*cos| stays below 2^33
  localparam int unsigned MAGW = 34;
  localparam int unsigned DIAW = 16;

  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
  localparam int unsigned ANG_FULL = 36000;
  localparam int unsigned ANG_QUAD = 9000;

  localparam logic signed [23:0] ATAN_TAB [16] = '{
    24'sd1152000, 24'sd680065, 24'sd359328, 24'sd182400,
    24'sd91554, 24'sd45822, 24'sd22916, 24'sd11459,
    24'sd5730, 24'sd2865, 24'sd1432, 24'sd716,
    24'sd358, 24'sd179, 24'sd90, 24'sd45
  };

  typedef enum logic [2:0] {
    COR_IDLE,
    COR_REDUCE,
    COR_ROTATE,
    COR_MAP,
    COR_DONE
  } cor_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_PROD1,
    ST_PROD2,
    ST_DIAM,
    ST_COEF,
    ST_ACCUM,
    ST_DONE
  } top_state_e;

  typedef struct packed {
    logic               done;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } trig_t;

  // round half up from Q2.30 to Q1.15, clamped to +-32767
  function automatic logic signed [15:0] clamp15(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [32:0] r;
    t = {v[31], v} + 33'sd16384;
    r = t >>> 15;
    if (r > 33'sd32767) begin
      return 16'sd32767;
    end else if (r < -33'sd32767) begin
      return -16'sd32767;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [47:0] sat_pos(input logic signed [64:0] v);
    if (v > 65'sh0_0000_7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -65'sh0_0000_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  function automatic logic signed [39:0] sat_tot(input logic signed [40:0] v);
    if (v > 41'sh0_7F_FFFF_FFFF) begin
      return 40'sh7F_FFFF_FFFF;
    end else if (v < -41'sh0_80_0000_0000) begin
      return 40'sh80_0000_0000;
    end
    return v[39:0];
  endfunction

endpackage

/* rtl/mow_serial_mult.sv */
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on nothing; full product is held until the next start
module mow_serial_mult #(
  parameter int unsigned WA = 50,
  parameter int unsigned WB = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  output logic             busy_o,
  output logic [WA+WB-1:0] prod_o
);

  localparam int unsigned CW = $clog2(WB + 1);

  logic [WA-1:0] a_q;
  logic [WA-1:0] acc_q, acc_d;
  logic [WB-1:0] b_q, b_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [WA:0]   sum;

  always_comb begin
    sum = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : '0);
    acc_d = sum[WA:1];
    b_d = {sum[0], b_q[WB-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= CW'(WB);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      acc_q <= '0;
      b_q <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q <= b_d;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = {acc_q, b_q};

endmodule

/* rtl/mow_cordic.sv */
// heading reduction to a quadrant plus a 16-step rotation cordic, one step per cycle
// depends on mow_pkg (angle table, clamp, trig_t)
module mow_cordic
  import mow_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] heading_i,
  output trig_t              trig_o
);

  cor_state_e state_q, state_d;

  logic signed [17:0] ang_q;
  logic [1:0]         quad_q;
  logic signed [31:0] x_q, y_q;
  logic signed [23:0] z_q;
  logic [3:0]         it_q;
  logic signed [15:0] cos_q, sin_q;
  logic signed [31:0] dx, dy;
  logic signed [15:0] c0, s0;
  logic               ang_neg, ang_over, ang_quad;

  assign ang_neg = ang_q < 18'sd0;
  assign ang_over = ang_q >= 18'(ANG_FULL);
  assign ang_quad = ang_q >= 18'(ANG_QUAD);
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign c0 = clamp15(x_q);
  assign s0 = clamp15(y_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      COR_IDLE, COR_DONE: begin
        if (start_i) state_d = COR_REDUCE;
      end
      COR_REDUCE: begin
        if (!ang_neg && !ang_over && !ang_quad) state_d = COR_ROTATE;
      end
      COR_ROTATE: begin
        if (it_q == 4'd15) state_d = COR_MAP;
      end
      COR_MAP: state_d = COR_DONE;
      default: state_d = COR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    trig_o.done = (state_q == COR_DONE);
    trig_o.cos_v = cos_q;
    trig_o.sin_v = sin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      COR_IDLE, COR_DONE: begin
        if (start_i) begin
          ang_q <= {heading_i[16], heading_i};
          quad_q <= 2'd0;
        end
      end
      COR_REDUCE: begin
        if (ang_neg) begin
          ang_q <= ang_q + 18'(ANG_FULL);
        end else if (ang_over) begin
          ang_q <= ang_q - 18'(ANG_FULL);
        end else if (ang_quad) begin
          ang_q <= ang_q - 18'(ANG_QUAD);
          quad_q <= quad_q + 2'd1;
        end else begin
          x_q <= CORDIC_X0;
          y_q <= '0;
          z_q <= {ang_q[15:0], 8'd0};
          it_q <= '0;
        end
      end
      COR_ROTATE: begin
        if (z_q >= 24'sd0) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - ATAN_TAB[it_q];
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + ATAN_TAB[it_q];
        end
        it_q <= it_q + 4'd1;
      end
      COR_MAP: begin
        case (quad_q)
          2'd0: begin
            cos_q <= c0;
            sin_q <= s0;
          end
          2'd1: begin
            cos_q <= -s0;
            sin_q <= c0;
          end
          2'd2: begin
            cos_q <= -c0;
            sin_q <= -s0;
          end
          default: begin
            cos_q <= s0;
            sin_q <= -c0;
          end
        endcase
      end
      default: ;
    endcase
  end

endmodule

/* rtl/mecanum_odometry_integrator_unit.sv */
// top level of the mecanum odometry integrator: control, totals, positions, output register
// depends on mow_pkg, mow_cordic and mow_serial_mult
//
//  channel   direction  handshake                payload
//  in        sink       in_valid_i / in_ready_o  four counts, heading, intervene flag
//  out       source     out_valid_o / out_ready_i positions, steps, totals
//  cfg       sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// each request runs through the two bit-serial multipliers, one multiplier bit
// per cycle each: a coefficient/trig round, then four multiply rounds.
// reset clears totals and positions and loads the register defaults.
// a finished result waits in the output register; the next request is taken
// meanwhile and stalls only at its own end if the output is still full.
module mecanum_odometry_integrator_unit
  import mow_pkg::*;
#(
  parameter int unsigned COUNTS_PER_REV = 1024,
  parameter int unsigned GEAR_NUM = 30,
  parameter int unsigned GEAR_DEN = 70,
  parameter int unsigned POS_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [15:0]    count_left_front_i,
  input  logic signed [15:0]    count_right_front_i,
  input  logic signed [15:0]    count_right_back_i,
  input  logic signed [15:0]    count_left_back_i,
  input  logic signed [16:0]    heading_i,
  input  logic                  intervene_active_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [47:0]    x_position_o,
  output logic signed [47:0]    y_position_o,
  output logic signed [17:0]    forward_step_o,
  output logic signed [17:0]    lateral_step_o,
  output logic signed [39:0]    forward_total_o,
  output logic signed [39:0]    lateral_total_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [63:0] KQ_DEN = 64'(GEAR_DEN) * 64'(COUNTS_PER_REV);
  localparam logic [63:0] KQ = (PI_Q40 * 64'(GEAR_NUM) + KQ_DEN / 2) / KQ_DEN;
  // room for the coefficient times a gain below 2.0
  localparam int unsigned KW = $clog2(KQ + 1) + 1;
  localparam int unsigned WB = (KW > DIAW) ? KW : DIAW;
  localparam int unsigned WA = (MAGW + DIAW > KW) ? MAGW + DIAW : KW;
  localparam int unsigned PW = WA + WB;
  localparam int unsigned SH = 65 - POS_FRAC_BITS;

  top_state_e state_q, state_d;

  logic [15:0]        diam_q, slip_q;
  logic signed [17:0] fq_q, lq_q;
  logic               intervene_q;
  logic [KW-1:0]      kx_q;
  logic signed [34:0] psx_q, psy_q;
  logic               negx_q, negy_q;
  logic signed [63:0] incx_q, incy_q;
  logic signed [47:0] x_acc_q, y_acc_q;
  logic signed [39:0] fwd_acc_q, lat_acc_q;
  logic               out_valid_q;
  logic signed [47:0] x_out_q, y_out_q;
  logic signed [17:0] fs_out_q, ls_out_q;
  logic signed [39:0] ft_out_q, lt_out_q;

  trig_t         trig;
  logic          cor_start;
  logic          mx_start, my_start, mx_busy, my_busy;
  logic [WA-1:0] mx_a, my_a;
  logic [WB-1:0] mx_b, my_b;
  logic [PW-1:0] mx_prod, my_prod;
  logic          units_idle, out_free;

  logic signed [17:0] fq_in, lq_in;
  logic [17:0]        fq_abs, lq_abs;
  logic [14:0]        c_abs, s_abs;
  logic [PW-1:0]      rnd_k;
  logic signed [34:0] sx1, sy1, plc, pls, px, py;
  logic [MAGW-1:0]    px_abs, py_abs;
  logic [PW:0]        rnd_x, rnd_y, shx, shy;
  logic signed [63:0] incx_d, incy_d;

  // left counts enter negated
  assign fq_in = -18'(count_left_back_i) - 18'(count_left_front_i)
               + 18'(count_right_back_i) + 18'(count_right_front_i);
  assign lq_in = -18'(count_left_back_i) + 18'(count_left_front_i)
               - 18'(count_right_back_i) + 18'(count_right_front_i);

  assign fq_abs = fq_q[17] ? 18'(-fq_q) : 18'(fq_q);
  assign lq_abs = lq_q[17] ? 18'(-lq_q) : 18'(lq_q);
  assign c_abs = trig.cos_v[15] ? 15'(-trig.cos_v) : trig.cos_v[14:0];
  assign s_abs = trig.sin_v[15] ? 15'(-trig.sin_v) : trig.sin_v[14:0];

  assign rnd_k = mx_prod + PW'(16384);

  always_comb begin
    sx1 = $signed({1'b0, mx_prod[MAGW-1:0]});
    sy1 = $signed({1'b0, my_prod[MAGW-1:0]});
    if (fq_q[17] ^ trig.sin_v[15]) sx1 = -sx1;
    if (fq_q[17] ^ trig.cos_v[15]) sy1 = -sy1;
    plc = $signed({1'b0, mx_prod[MAGW-1:0]});
    pls = $signed({1'b0, my_prod[MAGW-1:0]});
    if (lq_q[17] ^ trig.cos_v[15]) plc = -plc;
    if (lq_q[17] ^ trig.sin_v[15]) pls = -pls;
    px = -(psx_q + plc);
    py = psy_q - pls;
    px_abs = px[34] ? MAGW'(-px) : MAGW'(px);
    py_abs = py[34] ? MAGW'(-py) : MAGW'(py);
  end

  // symmetric rounding of the scaled magnitude
  always_comb begin
    rnd_x = {1'b0, mx_prod} + ((PW + 1)'(1) << (SH - 1));
    rnd_y = {1'b0, my_prod} + ((PW + 1)'(1) << (SH - 1));
    shx = rnd_x >> SH;
    shy = rnd_y >> SH;
    incx_d = $signed({1'b0, shx[62:0]});
    incy_d = $signed({1'b0, shy[62:0]});
    if (negx_q) incx_d = -incx_d;
    if (negy_q) incy_d = -incy_d;
  end

  assign units_idle = !mx_busy && !my_busy;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_TRIG;
      ST_TRIG:  if (trig.done && !mx_busy) state_d = ST_PROD1;
      ST_PROD1: if (units_idle) state_d = ST_PROD2;
      ST_PROD2: if (units_idle) state_d = ST_DIAM;
      ST_DIAM:  if (units_idle) state_d = ST_COEF;
      ST_COEF:  if (units_idle) state_d = ST_ACCUM;
      ST_ACCUM: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs to the units
  always_comb begin
    in_ready_o = 1'b0;
    cor_start = 1'b0;
    mx_start = 1'b0;
    my_start = 1'b0;
    mx_a = '0;
    mx_b = '0;
    my_a = '0;
    my_b = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cor_start = 1'b1;
          mx_start = 1'b1;
          mx_a = WA'(KQ);
          mx_b = WB'(slip_q);
        end
      end
      ST_TRIG: begin
        if (trig.done && !mx_busy) begin
          mx_start = 1'b1;
          my_start = 1'b1;
          mx_a = WA'(fq_abs);
          mx_b = WB'(s_abs);
          my_a = WA'(fq_abs);
          my_b = WB'(c_abs);
        end
      end
      ST_PROD1: begin
        if (units_idle) begin
          mx_start = 1'b1;
          my_start = 1'b1;
          mx_a = WA'(lq_abs);
          mx_b = WB'(c_abs);
          my_a = WA'(lq_abs);
          my_b = WB'(s_abs);
        end
      end
      ST_PROD2: begin
        if (units_idle) begin
          mx_start = 1'b1;
          my_start = 1'b1;
          mx_a = WA'(px_abs);
          mx_b = WB'(diam_q);
          my_a = WA'(py_abs);
          my_b = WB'(diam_q);
        end
      end
      ST_DIAM: begin
        if (units_idle) begin
          mx_start = 1'b1;
          my_start = 1'b1;
          mx_a = WA'(mx_prod[MAGW+DIAW-1:0]);
          mx_b = WB'(kx_q);
          my_a = WA'(my_prod[MAGW+DIAW-1:0]);
          my_b = WB'(KQ);
        end
      end
      ST_COEF, ST_ACCUM, ST_DONE: ;
      default: ;
    endcase
  end

  mow_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cor_start),
    .heading_i (heading_i),
    .trig_o    (trig)
  );

  mow_serial_mult #(.WA(WA), .WB(WB)) u_mult_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mx_start),
    .a_i     (mx_a),
    .b_i     (mx_b),
    .busy_o  (mx_busy),
    .prod_o  (mx_prod)
  );

  mow_serial_mult #(.WA(WA), .WB(WB)) u_mult_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (my_start),
    .a_i     (my_a),
    .b_i     (my_b),
    .busy_o  (my_busy),
    .prod_o  (my_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      diam_q <= WHEEL_DIAMETER_RST;
      slip_q <= X_SLIP_GAIN_RST;
      x_acc_q <= '0;
      y_acc_q <= '0;
      fwd_acc_q <= '0;
      lat_acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WHEEL_DIAMETER: diam_q <= cfg_data_i;
          REG_X_SLIP_GAIN:    slip_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && in_valid_i) begin
        fwd_acc_q <= sat_tot(41'(fwd_acc_q) + 41'(fq_in));
        lat_acc_q <= sat_tot(41'(lat_acc_q) + 41'(lq_in));
      end
      if (state_q == ST_ACCUM) begin
        x_acc_q <= sat_pos(65'(x_acc_q) + 65'(incx_q));
        y_acc_q <= sat_pos(65'(y_acc_q) + 65'(incy_q));
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      fq_q <= fq_in;
      lq_q <= lq_in;
      intervene_q <= intervene_active_i;
    end
    if (state_q == ST_TRIG && trig.done && !mx_busy) begin
      kx_q <= intervene_q ? KW'(KQ) : rnd_k[15 +: KW];
    end
    if (state_q == ST_PROD1 && units_idle) begin
      psx_q <= sx1;
      psy_q <= sy1;
    end
    if (state_q == ST_PROD2 && units_idle) begin
      negx_q <= px[34];
      negy_q <= py[34];
    end
    if (state_q == ST_COEF && units_idle) begin
      incx_q <= incx_d;
      incy_q <= incy_d;
    end
    if (state_q == ST_DONE && out_free) begin
      x_out_q <= x_acc_q;
      y_out_q <= y_acc_q;
      fs_out_q <= fq_q;
      ls_out_q <= lq_q;
      ft_out_q <= fwd_acc_q;
      lt_out_q <= lat_acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_position_o = x_out_q;
  assign y_position_o = y_out_q;
  assign forward_step_o = fs_out_q;
  assign lateral_step_o = ls_out_q;
  assign forward_total_o = ft_out_q;
  assign lateral_total_o = lt_out_q;

endmodule

/* tb/sv/mecanum_odometry_integrator_unit_tb.sv */
// self-checking testbench for mecanum_odometry_integrator_unit: directed table, then random requests
// depends on mow_pkg and the rtl of the block; a local predictor computes each expected result, but for typed steps
module mecanum_odometry_integrator_unit_tb;
  import mow_pkg::*;

  localparam int unsigned SHIFT_SH = 65 - 16;
  localparam int unsigned DOG_LIMIT = 20000;
  localparam int unsigned RAND_PER_PHASE = 425;

  typedef struct packed {
    logic signed [15:0] lf;
    logic signed [15:0] rf;
    logic signed [15:0] rb;
    logic signed [15:0] lb;
    logic signed [16:0] hd;
    logic               iv;
  } odo_req_t;

  typedef struct packed {
    logic signed [47:0] xp;
    logic signed [47:0] yp;
    logic signed [17:0] fs;
    logic signed [17:0] ls;
    logic signed [39:0] ft;
    logic signed [39:0] lt;
  } odo_res_t;

  // directed row: steps typed in where obvious
  typedef struct packed {
    odo_req_t           req;
    logic               typed;
    logic signed [17:0] fs;
    logic signed [17:0] ls;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] count_left_front_i = '0;
  logic signed [15:0] count_right_front_i = '0;
  logic signed [15:0] count_right_back_i = '0;
  logic signed [15:0] count_left_back_i = '0;
  logic signed [16:0] heading_i = '0;
  logic intervene_active_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [47:0] x_position_o;
  logic signed [47:0] y_position_o;
  logic signed [17:0] forward_step_o;
  logic signed [17:0] lateral_step_o;
  logic signed [39:0] forward_total_o;
  logic signed [39:0] lateral_total_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mecanum_odometry_integrator_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned diam_q, slip_q;
  longint pos_x, pos_y, fwd_sum, lat_sum;
  odo_res_t pending_q[$];
  logic typed_next = 1'b0;
  logic signed [17:0] typed_fs, typed_ls;
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  logic no_gaps = 1'b0;

  function automatic longint sat_w(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) return 32767;
    if (r < -32767) return -32767;
    return r;
  endfunction

  function automatic void cos_sin(longint h, output longint c, output longint s);
    longint a, x, y, z, dx, dy, c0, s0;
    a = h % 36000;
    if (a < 0) a += 36000;
    x = CORDIC_X0;
    y = 0;
    z = (a % 9000) * 256;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    c0 = round_q15(x);
    s0 = round_q15(y);
    case (a / 9000)
      0: begin c = c0; s = s0; end
      1: begin c = -s0; s = c0; end
      2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
  endfunction

  // symmetric rounding of |p|*d*k / 2^sh
  function automatic longint scale_cm(longint p, longint unsigned d, longint unsigned k);
    logic [127:0] prod;
    longint unsigned mag;
    mag = (p < 0) ? longint'(-p) : p;
    prod = {64'd0, mag * d} * {64'd0, k};
    prod = (prod + (128'd1 << (SHIFT_SH - 1))) >> SHIFT_SH;
    return (p < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic odo_res_t advance_odometry(odo_req_t r);
    longint lf, rf, rb, lb, fq, lq, c, s;
    longint unsigned ky, kx, den;
    odo_res_t o;
    lf = -longint'(r.lf);
    rf = r.rf;
    rb = r.rb;
    lb = -longint'(r.lb);
    fq = lb + lf + rb + rf;
    lq = lb - lf - rb + rf;
    den = 70 * 1024;
    ky = (PI_Q40 * 30 + den / 2) / den;
    kx = r.iv ? ky : (ky * slip_q + 16384) >> 15;
    fwd_sum = sat_w(fwd_sum + fq, 40);
    lat_sum = sat_w(lat_sum + lq, 40);
    cos_sin(longint'(r.hd), c, s);
    pos_x = sat_w(pos_x + scale_cm(-(fq * s + lq * c), diam_q, kx), 48);
    pos_y = sat_w(pos_y + scale_cm(fq * c - lq * s, diam_q, ky), 48);
    o.xp = pos_x[47:0];
    o.yp = pos_y[47:0];
    o.fs = fq[17:0];
    o.ls = lq[17:0];
    o.ft = fwd_sum[39:0];
    o.lt = lat_sum[39:0];
    return o;
  endfunction

  // monitor: predict on accepted requests, check accepted results, watchdog
  always @(posedge clk_i) begin
    odo_res_t e;
    odo_req_t r;
    if (!rst_ni) begin
      diam_q = WHEEL_DIAMETER_RST;
      slip_q = X_SLIP_GAIN_RST;
      pos_x = 0; pos_y = 0; fwd_sum = 0; lat_sum = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WHEEL_DIAMETER) diam_q = cfg_data_i;
        else if (cfg_idx_i == REG_X_SLIP_GAIN) slip_q = cfg_data_i;
      end
      idle_cycles++;
      if (in_valid_i && in_ready_o) begin
        idle_cycles = 0;
        r = '{count_left_front_i, count_right_front_i, count_right_back_i,
              count_left_back_i, heading_i, intervene_active_i};
        e = advance_odometry(r);
        if (typed_next) begin
          e.fs = typed_fs;
          e.ls = typed_ls;
        end
        pending_q.push_back(e);
      end
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        results_seen++;
        if (pending_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (x_position_o !== e.xp) begin
            $error("x_position exp %0d got %0d", e.xp, x_position_o); errors++;
          end
          if (y_position_o !== e.yp) begin
            $error("y_position exp %0d got %0d", e.yp, y_position_o); errors++;
          end
          if (forward_step_o !== e.fs) begin
            $error("forward_step exp %0d got %0d", e.fs, forward_step_o); errors++;
          end
          if (lateral_step_o !== e.ls) begin
            $error("lateral_step exp %0d got %0d", e.ls, lateral_step_o); errors++;
          end
          if (forward_total_o !== e.ft) begin
            $error("forward_total exp %0d got %0d", e.ft, forward_total_o); errors++;
          end
          if (lateral_total_o !== e.lt) begin
            $error("lateral_total exp %0d got %0d", e.lt, lateral_total_o); errors++;
          end
        end
      end
      if (idle_cycles >= DOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off to fill the block
  initial begin
    int w;
    int got;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      got = results_seen;
      if (got == 30) begin
        out_ready_i = 1'b0;
        for (int i = 0; i < 700; i++) @(negedge clk_i);
      end
      w = no_gaps ? 0 : $urandom_range(0, 3);
      out_ready_i = 1'b0;
      repeat (w) @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_request(odo_req_t r, logic typed, logic signed [17:0] fs,
                              logic signed [17:0] ls);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 3);
    if (w > 0) begin
      in_valid_i = 1'b0;
      repeat (w) @(negedge clk_i);
    end
    count_left_front_i = r.lf;
    count_right_front_i = r.rf;
    count_right_back_i = r.rb;
    count_left_back_i = r.lb;
    heading_i = r.hd;
    intervene_active_i = r.iv;
    typed_next = typed;
    typed_fs = fs;
    typed_ls = ls;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_and_write(logic [CFG_IDX_W-1:0] idx0, logic [15:0] v0,
                                 logic [15:0] v1);
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx0;
    cfg_data_i = v0;
    @(negedge clk_i);
    cfg_idx_i = REG_X_SLIP_GAIN;
    cfg_data_i = v1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic odo_req_t random_request();
    odo_req_t r;
    r = odo_req_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 3) == 0) begin
      r.lf = $signed(16'($urandom_range(0, 400))) - 16'sd200;
      r.rf = $signed(16'($urandom_range(0, 400))) - 16'sd200;
      r.rb = $signed(16'($urandom_range(0, 400))) - 16'sd200;
      r.lb = $signed(16'($urandom_range(0, 400))) - 16'sd200;
    end
    if ($urandom_range(0, 1) == 0) begin
      r.hd = $signed(17'($urandom_range(0, 72000))) - 17'sd36000;
    end
    return r;
  endfunction

  dir_row_t dir_tab[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 1'b0}, 1'b1, 18'sd0, 18'sd0},
    '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 17'sd0, 1'b0},
      1'b1, 18'sd131070, 18'sd0},
    '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 17'sd0, 1'b1},
      1'b1, 18'sd131070, 18'sd0},
    '{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 17'sd9000, 1'b0},
      1'b1, 18'sd0, 18'sd131070},
    '{'{16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 17'sd18000, 1'b1},
      1'b1, -18'sd65535, -18'sd65535},
    '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 17'sd27000, 1'b0},
      1'b1, 18'sd0, -18'sd131070},
    '{'{16'sd100, 16'sd100, 16'sd100, 16'sd100, -17'sd36000, 1'b0}, 1'b0, 18'sd0, 18'sd0},
    '{'{-16'sd100, 16'sd100, 16'sd100, -16'sd100, 17'sd36000, 1'b1}, 1'b0, 18'sd0, 18'sd0},
    '{'{-16'sd100, 16'sd100, 16'sd100, -16'sd100, 17'sd65535, 1'b0}, 1'b0, 18'sd0, 18'sd0},
    '{'{-16'sd100, 16'sd100, 16'sd100, -16'sd100, -17'sd65536, 1'b0}, 1'b0, 18'sd0, 18'sd0},
    '{'{16'sd5, 16'sd7, -16'sd3, 16'sd9, 17'sd4500, 1'b1}, 1'b0, 18'sd0, 18'sd0},
    '{'{-16'sd1000, 16'sd700, 16'sd20, 16'sd3, 17'sd8999, 1'b0}, 1'b0, 18'sd0, 18'sd0},
    '{'{16'sd1, -16'sd1, 16'sd1, -16'sd1, -17'sd1, 1'b1}, 1'b1, 18'sd0, 18'sd0},
    '{'{-16'sd1, 16'sd1, 16'sd1, -16'sd1, -17'sd9000, 1'b0}, 1'b1, 18'sd4, 18'sd0},
    '{'{16'sd1, 16'sd1, -16'sd1, -16'sd1, 17'sd35999, 1'b1}, 1'b1, 18'sd0, 18'sd4}
  };

  logic [15:0] diam_set[5] = '{16'd1613, 16'd0, 16'd65535, 16'd1, 16'd0};
  logic [15:0] slip_set[5] = '{16'd23918, 16'd65535, 16'd0, 16'd32768, 16'd0};

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].typed,
                                      dir_tab[i].fs, dir_tab[i].ls);
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        diam_set[4] = 16'($urandom);
        slip_set[4] = 16'($urandom);
      end
      drain_and_write(REG_WHEEL_DIAMETER, diam_set[ph + 1], slip_set[ph + 1]);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // stretches with no gaps on either side
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_request(random_request(), 1'b0, 18'sd0, 18'sd0);
      end
      no_gaps = 1'b0;
    end
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
